FILE: rtl/trfr_pkg.sv
// shared types and constants of the triangle filter resampler
// no dependencies; used by the top level, front end, divider and engine
package trfr_pkg;

	localparam int SRC_DIM_MAX = 256;
	localparam int DST_DIM_MAX = 128;
	localparam int WFRAC       = 16;
	localparam int IMG_AW      = 16;
	localparam int IMG_DEPTH   = SRC_DIM_MAX * SRC_DIM_MAX;
	localparam int TAP_AW      = 8;
	localparam int TAP_DEPTH   = SRC_DIM_MAX;
	localparam int WGT_W       = WFRAC + 1;
	localparam int DIV_NW      = 28;
	localparam int DIV_DW      = 20;
	localparam int DIV_CW      = 5;
	localparam int V_W         = 26;
	localparam int ACC_W       = 44;

	localparam logic [V_W-1:0] V_MAX = V_W'((256 << WFRAC) - 1);
	localparam logic [WGT_W-1:0] W_ONE = WGT_W'(1 << WFRAC);

	localparam logic FUNC_LOAD  = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	localparam logic [1:0] REG_SRC_WIDTH  = 2'd0;
	localparam logic [1:0] REG_SRC_HEIGHT = 2'd1;
	localparam logic [1:0] REG_DST_WIDTH  = 2'd2;
	localparam logic [1:0] REG_DST_HEIGHT = 2'd3;

	typedef struct packed {
		logic       func;
		logic [7:0] src_col;
		logic [7:0] src_row;
		logic [31:0] src_pixel;
		logic [6:0] dst_col;
		logic [6:0] dst_row;
	} item_t;

	typedef struct packed {
		logic [8:0] src_width;
		logic [8:0] src_height;
		logic [7:0] dst_width;
		logic [7:0] dst_height;
	} cfg_t;

	typedef struct packed {
		logic              start;
		logic [DIV_NW-1:0] num;
		logic [DIV_DW-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [DIV_NW-1:0] quo;
	} div_rsp_t;

endpackage

FILE: rtl/triangle_filter_image_resize_top.sv
// top level of the triangle filter image resampler
// depends on trfr_pkg, trfr_front and trfr_engine
//
// usage: items arrive on the s_ channel. tuser = 0 writes src_pixel into the
// 256 x 256 source store at (src_row, src_col) and gives no result. tuser = 1
// asks for output pixel (dst_row, dst_col) and gives one 32-bit transaction
// on the m_ channel. the size registers are written through cfg_we /
// cfg_index / cfg_data while the block is idle.
// a small queue in front takes items while the engine works; the engine
// handles one item at a time. in a query every tap weight costs one serial
// division (none when the window's triangle values sum to zero), the window
// bounds of each axis two more, and the single source-store read port walks
// each window column one word per cycle.
// reset empties the queue and the result register and loads the size
// registers with their defaults; the source store is not cleared. when the
// receiver stalls the result holds in its register, the engine waits and
// the queue fills up until s_tready drops.
module triangle_filter_image_resize_top #(
	parameter int FIFO_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // src_col, src_row, src_pixel, dst_col, dst_row, zero pad
	input  logic        s_tuser,   // func
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // out_pixel
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [8:0]  cfg_data
);

	trfr_pkg::cfg_t  cfg_q;
	trfr_pkg::item_t q_item;
	logic            q_valid, pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.src_width  <= 9'd256;
			cfg_q.src_height <= 9'd256;
			cfg_q.dst_width  <= 8'd112;
			cfg_q.dst_height <= 8'd112;
		end else if (cfg_we) begin
			unique case (cfg_index)
				trfr_pkg::REG_SRC_WIDTH:  cfg_q.src_width  <= cfg_data;
				trfr_pkg::REG_SRC_HEIGHT: cfg_q.src_height <= cfg_data;
				trfr_pkg::REG_DST_WIDTH:  cfg_q.dst_width  <= cfg_data[7:0];
				trfr_pkg::REG_DST_HEIGHT: cfg_q.dst_height <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	trfr_front #(.DEPTH(FIFO_DEPTH)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.pop      (pop),
		.q_valid  (q_valid),
		.q_item   (q_item)
	);

	trfr_engine u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

FILE: rtl/trfr_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module trfr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: rtl/trfr_front.sv
// front end: accepts stream items, unpacks and queues them for the engine
// depends on trfr_pkg
module trfr_front #(
	parameter int DEPTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [63:0]        s_tdata,
	input  logic               s_tuser,
	input  logic               pop,
	output logic               q_valid,
	output trfr_pkg::item_t    q_item
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	trfr_pkg::item_t        buf_q [DEPTH];
	trfr_pkg::item_t        in_item;
	logic [AW-1:0]          wptr_q, rptr_q;
	logic [AW:0]            cnt_q;
	logic                   push, do_pop;

	always_comb begin
		in_item.func      = s_tuser;
		in_item.src_col   = s_tdata[7:0];
		in_item.src_row   = s_tdata[15:8];
		in_item.src_pixel = s_tdata[47:16];
		in_item.dst_col   = s_tdata[54:48];
		in_item.dst_row   = s_tdata[61:55];
	end

	assign s_tready = (cnt_q != (AW+1)'(DEPTH));
	assign q_valid  = (cnt_q != '0);
	assign q_item   = buf_q[rptr_q];
	assign push     = s_tvalid && s_tready;
	assign do_pop   = pop && q_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == AW'(DEPTH-1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == AW'(DEPTH-1)) ? '0 : rptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

FILE: rtl/trfr_div.sv
// restoring divider, one quotient bit per cycle
// depends on trfr_pkg
module trfr_div (
	input  logic                clk,
	input  logic                arst_n,
	input  trfr_pkg::div_req_t  req,
	output trfr_pkg::div_rsp_t  rsp
);

	logic [trfr_pkg::DIV_NW-1:0] num_q, quo_q;
	logic [trfr_pkg::DIV_DW-1:0] den_q, rem_q;
	logic [trfr_pkg::DIV_CW-1:0] cnt_q;
	logic                        busy_q, done_q;
	logic [trfr_pkg::DIV_DW:0]   trial;
	logic                        fits;

	assign trial = {rem_q, num_q[trfr_pkg::DIV_NW-1]};
	assign fits  = (trial >= {1'b0, den_q});

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			num_q <= req.num;
			den_q <= req.den;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[trfr_pkg::DIV_NW-2:0], 1'b0};
			rem_q <= fits ? trfr_pkg::DIV_DW'(trial - {1'b0, den_q})
			              : trfr_pkg::DIV_DW'(trial);
			quo_q <= {quo_q[trfr_pkg::DIV_NW-2:0], fits};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == trfr_pkg::DIV_CW'(trfr_pkg::DIV_NW-1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

FILE: rtl/trfr_engine.sv
// back end: source store, per-axis weight tables and the filter sequencer
// depends on trfr_pkg, trfr_ram and trfr_div
module trfr_engine (
	input  logic               clk,
	input  logic               arst_n,
	input  trfr_pkg::cfg_t     cfg,
	input  logic               q_valid,
	input  trfr_pkg::item_t    q_item,
	output logic               pop,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [31:0]        m_tdata
);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_AXIS  = 4'd1;
	localparam logic [3:0] ST_LDIV  = 4'd2;
	localparam logic [3:0] ST_LWAIT = 4'd3;
	localparam logic [3:0] ST_RWAIT = 4'd4;
	localparam logic [3:0] ST_SUM   = 4'd5;
	localparam logic [3:0] ST_WGT   = 4'd6;
	localparam logic [3:0] ST_WDIV  = 4'd7;
	localparam logic [3:0] ST_MAC   = 4'd8;
	localparam logic [3:0] ST_DRAIN = 4'd9;
	localparam logic [3:0] ST_HACC  = 4'd10;
	localparam logic [3:0] ST_OUT   = 4'd11;

	logic [3:0]  state_q;
	logic        axis_h_q;
	logic [8:0]  sw_q, sh_q, s_q, m_q;
	logic [7:0]  dw_q, dh_q, d_q;
	logic [6:0]  dcol_q, drow_q, o_q;
	logic [16:0] c_q;
	logic [8:0]  left_q, right_q, i_q, j_q, nv_q, nh_q;
	logic [7:0]  lv_q, lh_q;
	logic [17:0] rsum_q;
	logic        p1_q;
	logic [trfr_pkg::V_W-1:0]   v_q   [4];
	logic [trfr_pkg::ACC_W-1:0] acc_q [4];
	logic        out_valid_q;
	logic [31:0] out_data_q;

	trfr_pkg::div_req_t div_req;
	trfr_pkg::div_rsp_t div_rsp;

	// clamped sizes and output coordinates of a new query
	logic [8:0]  sw_n, sh_n;
	logic [7:0]  dw_n, dh_n;
	logic [6:0]  dcol_n, drow_n;

	// triangle value of the tap at i_q and the window bound numerators
	logic [17:0] tap_pos;
	logic signed [18:0] tap_n;
	logic [17:0] tap_a;
	logic [9:0]  m2, tap_r;
	logic [16:0] lnum;
	logic [17:0] rnum;
	logic [8:0]  lo_right;

	logic                          img_we;
	logic [trfr_pkg::IMG_AW-1:0]   img_waddr, img_raddr;
	logic [31:0]                   img_rd;
	logic                          wgt_we, wgt_last;
	logic [trfr_pkg::WGT_W-1:0]    wgt_data, wv_rd, wh_rd;
	logic [trfr_pkg::TAP_AW-1:0]   wgt_waddr;
	logic [7:0]                    row_a, col_a;
	logic [trfr_pkg::V_W-1:0]      vsat [4];
	logic [trfr_pkg::ACC_W:0]      rnd  [4];
	logic [31:0]                   res;

	always_comb begin
		sw_n = (cfg.src_width == '0) ? 9'd1 :
		       (cfg.src_width > 9'(trfr_pkg::SRC_DIM_MAX)) ? 9'(trfr_pkg::SRC_DIM_MAX) :
		       cfg.src_width;
		sh_n = (cfg.src_height == '0) ? 9'd1 :
		       (cfg.src_height > 9'(trfr_pkg::SRC_DIM_MAX)) ? 9'(trfr_pkg::SRC_DIM_MAX) :
		       cfg.src_height;
		dw_n = (cfg.dst_width == '0) ? 8'd1 :
		       (cfg.dst_width > 8'(trfr_pkg::DST_DIM_MAX)) ? 8'(trfr_pkg::DST_DIM_MAX) :
		       cfg.dst_width;
		dh_n = (cfg.dst_height == '0) ? 8'd1 :
		       (cfg.dst_height > 8'(trfr_pkg::DST_DIM_MAX)) ? 8'(trfr_pkg::DST_DIM_MAX) :
		       cfg.dst_height;
		dcol_n = ({1'b0, q_item.dst_col} > dw_n - 8'd1) ? 7'(dw_n - 8'd1) : q_item.dst_col;
		drow_n = ({1'b0, q_item.dst_row} > dh_n - 8'd1) ? 7'(dh_n - 8'd1) : q_item.dst_row;
	end

	always_comb begin
		m2      = {m_q, 1'b0};
		tap_pos = 18'({d_q, 1'b0} * i_q) + 18'(d_q);
		tap_n   = $signed({1'b0, tap_pos}) - $signed({2'b0, c_q});
		tap_a   = tap_n[18] ? 18'(-tap_n) : tap_n[17:0];
		tap_r   = (tap_a < 18'(m2)) ? 10'(18'(m2) - tap_a) : 10'd0;
		lnum    = (c_q < 17'(m2)) ? 17'd0 : c_q - 17'(m2);
		rnum    = 18'(c_q) + 18'(m2) + 18'({d_q, 1'b0}) - 18'd1;
		lo_right = left_q + 9'd1;
	end

	always_comb begin
		div_req.start = 1'b0;
		div_req.num   = '0;
		div_req.den   = trfr_pkg::DIV_DW'({d_q, 1'b0});
		unique case (state_q)
			ST_LDIV: begin
				div_req.start = 1'b1;
				div_req.num   = trfr_pkg::DIV_NW'(lnum);
			end
			ST_LWAIT: begin
				div_req.start = div_rsp.done;
				div_req.num   = trfr_pkg::DIV_NW'(rnum);
			end
			ST_WGT: begin
				div_req.start = (rsum_q != '0);
				div_req.num   = trfr_pkg::DIV_NW'({tap_r, 17'd0}) +
				                trfr_pkg::DIV_NW'(rsum_q);
				div_req.den   = trfr_pkg::DIV_DW'({rsum_q, 1'b0});
			end
			default: begin
			end
		endcase
	end

	trfr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// weight of the current tap, either from the divider or the degenerate window
	always_comb begin
		wgt_we    = ((state_q == ST_WGT) && (rsum_q == '0)) ||
		            ((state_q == ST_WDIV) && div_rsp.done);
		wgt_last  = wgt_we && (i_q == right_q - 9'd1);
		wgt_data  = (state_q == ST_WDIV) ? div_rsp.quo[trfr_pkg::WGT_W-1:0] :
		            (i_q == left_q) ? trfr_pkg::W_ONE : '0;
		wgt_waddr = trfr_pkg::TAP_AW'(i_q - left_q);
	end

	assign pop       = (state_q == ST_IDLE);
	assign img_we    = (state_q == ST_IDLE) && q_valid && (q_item.func == trfr_pkg::FUNC_LOAD);
	assign img_waddr = {q_item.src_row, q_item.src_col};
	assign row_a     = 8'(9'(lv_q) + i_q);
	assign col_a     = 8'(9'(lh_q) + j_q);
	assign img_raddr = {row_a, col_a};

	trfr_ram #(.WIDTH(32), .DEPTH(trfr_pkg::IMG_DEPTH)) u_img (
		.clk   (clk),
		.we    (img_we),
		.waddr (img_waddr),
		.wdata (q_item.src_pixel),
		.raddr (img_raddr),
		.rdata (img_rd)
	);

	trfr_ram #(.WIDTH(trfr_pkg::WGT_W), .DEPTH(trfr_pkg::TAP_DEPTH)) u_wv (
		.clk   (clk),
		.we    (wgt_we && !axis_h_q),
		.waddr (wgt_waddr),
		.wdata (wgt_data),
		.raddr (i_q[trfr_pkg::TAP_AW-1:0]),
		.rdata (wv_rd)
	);

	trfr_ram #(.WIDTH(trfr_pkg::WGT_W), .DEPTH(trfr_pkg::TAP_DEPTH)) u_wh (
		.clk   (clk),
		.we    (wgt_we && axis_h_q),
		.waddr (wgt_waddr),
		.wdata (wgt_data),
		.raddr (j_q[trfr_pkg::TAP_AW-1:0]),
		.rdata (wh_rd)
	);

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			vsat[k] = (v_q[k] > trfr_pkg::V_MAX) ? trfr_pkg::V_MAX : v_q[k];
			rnd[k]  = {1'b0, acc_q[k]} + (trfr_pkg::ACC_W+1)'(64'd1 << (2*trfr_pkg::WFRAC-1));
			res[8*k +: 8] = (rnd[k][trfr_pkg::ACC_W:2*trfr_pkg::WFRAC] > 13'd255) ? 8'hff :
			                rnd[k][2*trfr_pkg::WFRAC +: 8];
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// datapath registers
	always_ff @(posedge clk) begin
		if (p1_q) begin
			for (int k = 0; k < 4; k++) begin
				v_q[k] <= v_q[k] + trfr_pkg::V_W'(wv_rd * img_rd[8*k +: 8]);
			end
		end
		unique case (state_q)
			ST_IDLE: begin
				sw_q <= sw_n; sh_q <= sh_n; dw_q <= dw_n; dh_q <= dh_n;
				dcol_q <= dcol_n; drow_q <= drow_n;
				s_q <= sh_n; d_q <= dh_n; o_q <= drow_n;
			end
			ST_AXIS: begin
				m_q <= (s_q > 9'(d_q)) ? s_q : 9'(d_q);
				c_q <= 17'({o_q, 1'b1} * s_q);
			end
			ST_LWAIT: begin
				if (div_rsp.done) begin
					left_q <= (div_rsp.quo > trfr_pkg::DIV_NW'(s_q - 9'd1)) ?
					          s_q - 9'd1 : div_rsp.quo[8:0];
				end
			end
			ST_RWAIT: begin
				if (div_rsp.done) begin
					right_q <= (div_rsp.quo < trfr_pkg::DIV_NW'(lo_right)) ? lo_right :
					           (div_rsp.quo > trfr_pkg::DIV_NW'(s_q)) ? s_q :
					           div_rsp.quo[8:0];
					i_q    <= left_q;
					rsum_q <= '0;
				end
			end
			ST_SUM: begin
				rsum_q <= rsum_q + 18'(tap_r);
				i_q    <= (i_q == right_q - 9'd1) ? left_q : i_q + 9'd1;
			end
			ST_DRAIN: begin
			end
			ST_HACC: begin
				for (int k = 0; k < 4; k++) begin
					acc_q[k] <= acc_q[k] + trfr_pkg::ACC_W'(wh_rd * vsat[k][23:0]);
					v_q[k]   <= '0;
				end
			end
			ST_OUT: begin
				if (!out_valid_q || m_tready) begin
					out_data_q <= res;
				end
			end
			default: begin
			end
		endcase
		if (state_q == ST_MAC) begin
			i_q <= i_q + 9'd1;
		end
		if (state_q == ST_HACC) begin
			i_q <= '0;
			j_q <= j_q + 9'd1;
		end
		if (wgt_we) begin
			if (!wgt_last) begin
				i_q <= i_q + 9'd1;
			end else if (!axis_h_q) begin
				lv_q <= left_q[7:0];
				nv_q <= right_q - left_q;
				s_q <= sw_q; d_q <= dw_q; o_q <= dcol_q;
			end else begin
				lh_q <= left_q[7:0];
				nh_q <= right_q - left_q;
				i_q  <= '0;
				j_q  <= '0;
				for (int k = 0; k < 4; k++) begin
					v_q[k]   <= '0;
					acc_q[k] <= '0;
				end
			end
		end
	end

	// sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			axis_h_q    <= 1'b0;
			p1_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			p1_q <= (state_q == ST_MAC);
			if ((state_q == ST_OUT) && (!out_valid_q || m_tready)) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (q_valid && (q_item.func == trfr_pkg::FUNC_QUERY)) begin
						axis_h_q <= 1'b0;
						state_q  <= ST_AXIS;
					end
				end
				ST_AXIS:  state_q <= ST_LDIV;
				ST_LDIV:  state_q <= ST_LWAIT;
				ST_LWAIT: if (div_rsp.done) state_q <= ST_RWAIT;
				ST_RWAIT: if (div_rsp.done) state_q <= ST_SUM;
				ST_SUM:   if (i_q == right_q - 9'd1) state_q <= ST_WGT;
				// start the division of a tap weight, or after the last weight of an axis go to the next axis or to the filter loop
				ST_WGT: begin
					if (rsum_q != '0) begin
						state_q <= ST_WDIV;
					end else if (wgt_last) begin
						axis_h_q <= 1'b1;
						state_q  <= axis_h_q ? ST_MAC : ST_AXIS;
					end
				end
				ST_WDIV: begin
					if (wgt_last) begin
						axis_h_q <= 1'b1;
						state_q  <= axis_h_q ? ST_MAC : ST_AXIS;
					end else if (div_rsp.done) begin
						state_q <= ST_WGT;
					end
				end
				ST_MAC:   if (i_q == nv_q - 9'd1) state_q <= ST_DRAIN;
				ST_DRAIN: state_q <= ST_HACC;
				ST_HACC:  state_q <= (j_q == nh_q - 9'd1) ? ST_OUT : ST_MAC;
				ST_OUT: begin
					if (!out_valid_q || m_tready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

FILE: rtl/trfr_checker.sv
// port-level checks of the resampler top level, attached by bind
// depends only on the top level's ports
module trfr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [63:0] s_tdata,
	input logic        s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic        cfg_we,
	input logic [1:0]  cfg_index,
	input logic [8:0]  cfg_data
);

	// no result may be pending while in reset
	a_rst_out: assert property (@(posedge clk) !arst_n |-> !m_tvalid)
		else $error("result valid during reset");

	// queue is empty right out of reset, so items are taken
	a_rst_rdy: assert property (@(posedge clk) !arst_n |-> s_tready)
		else $error("input not ready during reset");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	a_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result changed while stalled");

endmodule

bind triangle_filter_image_resize_top trfr_checker u_trfr_checker (.*);

FILE: tb/sv/triangle_filter_image_resize_top_tb.sv
// self-checking testbench of the triangle filter image resampler
// depends on trfr_pkg and triangle_filter_image_resize_top; predicts the random queries in place
module triangle_filter_image_resize_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_LIMIT = 20000;
	localparam int PHASE_ITEMS = 160;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;   // src_col, src_row, src_pixel, dst_col, dst_row, zero pad
	logic        s_tuser;   // func
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;   // out_pixel
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [8:0]  cfg_data;

	triangle_filter_image_resize_top dut (.*);

	logic [31:0] image_mirror [trfr_pkg::IMG_DEPTH];
	bit          pixel_loaded [trfr_pkg::IMG_DEPTH];
	longint unsigned size_sw, size_sh, size_dw, size_dh;
	longint unsigned col_wgt [512];
	longint unsigned row_wgt [512];
	logic [31:0] pixel_due [$];
	int          mismatches;
	int          burst_left;
	int          idle_cycles;
	bit          hold_req;

	typedef struct {
		logic        func;
		logic [7:0]  scol;
		logic [7:0]  srow;
		logic [31:0] pix;
		logic [6:0]  dcol;
		logic [6:0]  drow;
		bit          known;
		logic [31:0] pixel_exp;
	} stim_row_t;

	// a 1x1 source gives one tap of weight exactly one, so the pixel passes unchanged
	stim_row_t directed_rows [] = '{
		'{trfr_pkg::FUNC_LOAD,  8'd0,   8'd0,   32'hffff_ffff, 7'd0,   7'd0,   0, 32'h0},
		'{trfr_pkg::FUNC_QUERY, 8'd0,   8'd0,   32'h0,         7'd0,   7'd0,   1, 32'hffff_ffff},
		'{trfr_pkg::FUNC_QUERY, 8'd255, 8'd255, 32'hffff_ffff, 7'd127, 7'd127, 1, 32'hffff_ffff},
		'{trfr_pkg::FUNC_LOAD,  8'd0,   8'd0,   32'h0,         7'd127, 7'd127, 0, 32'h0},
		'{trfr_pkg::FUNC_QUERY, 8'd0,   8'd0,   32'h0,         7'd64,  7'd3,   1, 32'h0},
		'{trfr_pkg::FUNC_LOAD,  8'd255, 8'd255, 32'ha5a5_5a5a, 7'd0,   7'd0,   0, 32'h0},
		'{trfr_pkg::FUNC_LOAD,  8'd0,   8'd0,   32'h1234_5678, 7'd0,   7'd0,   0, 32'h0},
		'{trfr_pkg::FUNC_QUERY, 8'd0,   8'd0,   32'h0,         7'd5,   7'd90,  1, 32'h1234_5678},
		'{trfr_pkg::FUNC_LOAD,  8'd0,   8'd0,   32'h80ff_007f, 7'd0,   7'd0,   0, 32'h0},
		'{trfr_pkg::FUNC_QUERY, 8'd0,   8'd0,   32'h0,         7'd127, 7'd0,   1, 32'h80ff_007f}
	};

	// per phase: src width, src height, dst width, dst height (raw register values)
	int phase_cfg [][4] = '{
		'{8, 8, 8, 8},
		'{16, 12, 5, 7},
		'{0, 511, 0, 255},
		'{256, 256, 128, 128},
		'{7, 3, 128, 1},
		'{20, 30, 40, 10},
		'{256, 9, 112, 112},
		'{256, 256, 112, 112}
	};

	always #10 clk = ~clk;

	function automatic longint unsigned clamp_u(longint unsigned v, longint unsigned lo,
		longint unsigned hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	// normalized triangle weights of one axis
	function automatic longint unsigned axis_taps(longint unsigned s, longint unsigned d,
		longint unsigned o, output longint unsigned first, output longint unsigned w [512]);
		longint unsigned m, c, left, right, cnt, total, a;
		longint n;
		m = (s > d) ? s : d;
		c = (2 * o + 1) * s;
		total = 0;
		left = (c < 2 * m) ? 0 : (c - 2 * m) / (2 * d);
		if (left > s - 1) left = s - 1;
		right = (c + 2 * m + 2 * d - 1) / (2 * d);
		right = clamp_u(right, left + 1, s);
		cnt = right - left;
		for (int i = 0; i < cnt; i++) begin
			n = longint'(2 * d * (left + i) + d) - longint'(c);
			a = (n < 0) ? -n : n;
			w[i] = (a < 2 * m) ? 2 * m - a : 0;
			total += w[i];
		end
		for (int i = 0; i < cnt; i++) begin
			if (total == 0)
				w[i] = (i == 0) ? (64'd1 << trfr_pkg::WFRAC) : 0;
			else
				w[i] = (w[i] * (64'd1 << (trfr_pkg::WFRAC + 1)) + total) / (2 * total);
		end
		first = left;
		return cnt;
	endfunction

	function automatic void query_window(logic [6:0] dcol, logic [6:0] drow,
		output longint unsigned lh, output longint unsigned nh,
		output longint unsigned lv, output longint unsigned nv);
		longint unsigned sw, sh, dw, dh, oc, orow;
		sw = clamp_u(size_sw, 1, trfr_pkg::SRC_DIM_MAX);
		sh = clamp_u(size_sh, 1, trfr_pkg::SRC_DIM_MAX);
		dw = clamp_u(size_dw, 1, trfr_pkg::DST_DIM_MAX);
		dh = clamp_u(size_dh, 1, trfr_pkg::DST_DIM_MAX);
		oc = (dcol > dw - 1) ? dw - 1 : dcol;
		orow = (drow > dh - 1) ? dh - 1 : drow;
		nh = axis_taps(sw, dw, oc, lh, col_wgt);
		nv = axis_taps(sh, dh, orow, lv, row_wgt);
	endfunction

	function automatic logic [31:0] resampled_pixel(logic [6:0] dcol, logic [6:0] drow);
		longint unsigned lh, nh, lv, nv, ch;
		longint unsigned acc [4];
		longint unsigned vsum [4];
		logic [31:0] p, res;
		acc = '{0, 0, 0, 0};
		res = '0;
		query_window(dcol, drow, lh, nh, lv, nv);
		for (int j = 0; j < nh; j++) begin
			vsum = '{0, 0, 0, 0};
			for (int i = 0; i < nv; i++) begin
				p = image_mirror[(lv + i) * trfr_pkg::SRC_DIM_MAX + lh + j];
				for (int k = 0; k < 4; k++)
					vsum[k] += row_wgt[i] * p[24 - 8 * k +: 8];
			end
			for (int k = 0; k < 4; k++) begin
				if (vsum[k] > trfr_pkg::V_MAX) vsum[k] = trfr_pkg::V_MAX;
				acc[k] += col_wgt[j] * vsum[k];
			end
		end
		for (int k = 0; k < 4; k++) begin
			ch = (acc[k] + (64'd1 << (2 * trfr_pkg::WFRAC - 1))) >> (2 * trfr_pkg::WFRAC);
			if (ch > 255) ch = 255;
			res[24 - 8 * k +: 8] = ch[7:0];
		end
		return res;
	endfunction

	// bursts of random length separated by random gaps
	task automatic send_item(logic func, logic [7:0] scol, logic [7:0] srow, logic [31:0] pix,
		logic [6:0] dcol, logic [6:0] drow, bit known, logic [31:0] pixel_exp);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		s_tvalid <= 1'b1;
		s_tuser <= func;
		s_tdata <= {2'b00, drow, dcol, pix, srow, scol};
		do @(posedge clk); while (!s_tready);
		burst_left--;
		if (func == trfr_pkg::FUNC_LOAD) begin
			image_mirror[{srow, scol}] = pix;
			pixel_loaded[{srow, scol}] = 1'b1;
		end else begin
			pixel_due.push_back(known ? pixel_exp : resampled_pixel(dcol, drow));
		end
	endtask

	function automatic logic [31:0] random_pixel();
		case ($urandom_range(0, 5))
			0: return 32'h0;
			1: return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	// loads every pixel of the window that was never written, then asks for the pixel
	task automatic issue_query(logic [6:0] dcol, logic [6:0] drow, inout int sent);
		longint unsigned lh, nh, lv, nv;
		int addr;
		query_window(dcol, drow, lh, nh, lv, nv);
		for (int i = 0; i < nv; i++)
			for (int j = 0; j < nh; j++) begin
				addr = (lv + i) * trfr_pkg::SRC_DIM_MAX + lh + j;
				if (!pixel_loaded[addr]) begin
					send_item(trfr_pkg::FUNC_LOAD, addr[7:0], addr[15:8], random_pixel(),
						7'($urandom), 7'($urandom), 0, '0);
					sent++;
				end
			end
		send_item(trfr_pkg::FUNC_QUERY, 8'($urandom), 8'($urandom), $urandom, dcol, drow,
			0, '0);
		sent++;
	endtask

	task automatic wait_idle();
		if (s_tvalid) s_tvalid <= 1'b0;
		burst_left = 0;
		while (pixel_due.size() != 0) @(posedge clk);
		// trailing loads give no transaction, so let the engine drain them
		repeat (40) @(posedge clk);
	endtask

	// leaves the write enable high; set_sizes lowers it after the last register
	task automatic write_reg(logic [1:0] idx, int value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value[8:0];
		@(posedge clk);
		case (idx)
			trfr_pkg::REG_SRC_WIDTH:  size_sw = value & 9'h1ff;
			trfr_pkg::REG_SRC_HEIGHT: size_sh = value & 9'h1ff;
			trfr_pkg::REG_DST_WIDTH:  size_dw = value & 8'hff;
			trfr_pkg::REG_DST_HEIGHT: size_dh = value & 8'hff;
			default: ;
		endcase
	endtask

	task automatic set_sizes(int sw, int sh, int dw, int dh);
		write_reg(trfr_pkg::REG_SRC_WIDTH, sw);
		write_reg(trfr_pkg::REG_SRC_HEIGHT, sh);
		write_reg(trfr_pkg::REG_DST_WIDTH, dw);
		write_reg(trfr_pkg::REG_DST_HEIGHT, dh);
		cfg_we <= 1'b0;
	endtask

	// receiver stall pattern, with one long hold-off on request
	initial begin
		int mode;
		int cnt;
		bit held;
		mode = 0;
		cnt = 0;
		held = 0;
		forever begin
			if (hold_req && !held) begin
				m_tready <= 1'b0;
				repeat (600) @(posedge clk);
				held = 1;
			end else begin
				if (cnt % 64 == 0) mode = $urandom_range(0, 2);
				cnt++;
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= 1'($urandom_range(0, 1));
					default: m_tready <= ($urandom_range(0, 3) == 0);
				endcase
				@(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pixel_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected out_pixel %08h", m_tdata);
			end else begin
				if (m_tdata !== pixel_due[0]) begin
					mismatches++;
					if (mismatches <= 10)
						$display("out_pixel mismatch: expected %08h actual %08h",
							pixel_due[0], m_tdata);
				end
				void'(pixel_due.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		int sent;
		clk = 1'b0;
		hold_req = 0;
		arst_n = 1'b1;
		// drop reset once every process waits on it
		#1;
		arst_n = 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= trfr_pkg::FUNC_LOAD;
		cfg_we <= 1'b0;
		cfg_index <= trfr_pkg::REG_SRC_WIDTH;
		cfg_data <= '0;
		burst_left = 0;
		size_sw = 256;
		size_sh = 256;
		size_dw = 112;
		size_dh = 112;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		set_sizes(1, 1, 128, 128);
		foreach (directed_rows[r])
			send_item(directed_rows[r].func, directed_rows[r].scol, directed_rows[r].srow,
				directed_rows[r].pix, directed_rows[r].dcol, directed_rows[r].drow,
				directed_rows[r].known, directed_rows[r].pixel_exp);

		foreach (phase_cfg[p]) begin
			wait_idle();
			set_sizes(phase_cfg[p][0], phase_cfg[p][1], phase_cfg[p][2], phase_cfg[p][3]);
			if (p == 2) hold_req = 1;
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				if ($urandom_range(0, 4) == 0) begin
					send_item(trfr_pkg::FUNC_LOAD, 8'($urandom), 8'($urandom), random_pixel(),
						7'($urandom), 7'($urandom), 0, '0);
					sent++;
				end else begin
					issue_query(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)), sent);
				end
			end
		end

		wait_idle();
		if (mismatches == 0 && pixel_due.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
